[src/bdalu_pkg.sv]
// bdalu_pkg: word types shared by the binary/decimal add-subtract alu
// no dependencies
package bdalu_pkg;

    typedef enum logic
    {
        ACT_ADC = 1'b0,
        ACT_SBC = 1'b1
    } action_t;

    typedef struct packed
    {
        action_t    action;
        logic [7:0] acc_in;
        logic [7:0] operand;
        logic       carry_in;
        logic       decimal_mode;
    } in_word_t;

    typedef struct packed
    {
        logic [7:0] acc_out;
        logic       carry_out;
        logic       overflow_out;
        logic       zero_out;
        logic       negative_out;
    } out_word_t;

    localparam logic [3:0] BCD_MAX_DIGIT = 4'd9;
    localparam logic [3:0] BCD_FIX       = 4'd6;

endpackage

[src/bdalu_core.sv]
// bdalu_core: combinational add-with-carry / subtract-with-borrow datapath
// binary and packed-bcd modes with nmos flag rules; depends on bdalu_pkg
module bdalu_core
    import bdalu_pkg::*;
(
    input  in_word_t  in_word,
    output out_word_t out_word
);

    logic [7:0] a;
    logic [7:0] b;
    logic       c;
    logic       borrow;

    logic [8:0] sum;
    logic [4:0] add_lo;
    logic [5:0] add_lo_fix;
    logic [4:0] add_hi;
    logic [5:0] add_hi_fix;
    logic       add_dec_v;

    logic [8:0] diff;
    logic [4:0] sub_lo;
    logic [3:0] sub_lo_fix;
    logic [4:0] sub_hi;
    logic [4:0] sub_hi_adj;
    logic [3:0] sub_hi_fix;

    assign a      = in_word.acc_in;
    assign b      = in_word.operand;
    assign c      = in_word.carry_in;
    assign borrow = ~in_word.carry_in;

    // add path
    assign sum    = {1'b0, a} + {1'b0, b} + {8'd0, c};
    assign add_lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c};

    always_comb
    begin
        if (add_lo > {1'b0, BCD_MAX_DIGIT})
        begin
            add_lo_fix = {1'b0, add_lo} + {2'b00, BCD_FIX};
        end
        else
        begin
            add_lo_fix = {1'b0, add_lo};
        end
    end

    assign add_hi    = {1'b0, a[7:4]} + {1'b0, b[7:4]} + {4'd0, (add_lo_fix[5:4] != 2'b00)};
    assign add_dec_v = (add_hi[3] ^ a[7]) & ~(a[7] ^ b[7]);

    always_comb
    begin
        if (add_hi > {1'b0, BCD_MAX_DIGIT})
        begin
            add_hi_fix = {1'b0, add_hi} + {2'b00, BCD_FIX};
        end
        else
        begin
            add_hi_fix = {1'b0, add_hi};
        end
    end

    // subtract path
    assign diff       = {1'b0, a} - {1'b0, b} - {8'd0, borrow};
    assign sub_lo     = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, borrow};
    assign sub_lo_fix = sub_lo[4] ? (sub_lo[3:0] - BCD_FIX) : sub_lo[3:0];
    assign sub_hi     = {1'b0, a[7:4]} - {1'b0, b[7:4]};
    assign sub_hi_adj = sub_hi - {4'd0, sub_lo[4]};
    assign sub_hi_fix = sub_hi_adj[4] ? (sub_hi_adj[3:0] - BCD_FIX) : sub_hi_adj[3:0];

    always_comb
    begin
        case (in_word.action)
            ACT_SBC:
            begin
                out_word.carry_out    = ~diff[8];
                out_word.overflow_out = (a[7] ^ diff[7]) & (a[7] ^ b[7]);
                out_word.zero_out     = (diff[7:0] == 8'd0);
                out_word.negative_out = diff[7];
                out_word.acc_out      = in_word.decimal_mode ? {sub_hi_fix, sub_lo_fix}
                                                             : diff[7:0];
            end
            default:
            begin
                out_word.zero_out = (sum[7:0] == 8'd0);
                if (in_word.decimal_mode)
                begin
                    out_word.carry_out    = (add_hi_fix[5:4] != 2'b00);
                    out_word.overflow_out = add_dec_v;
                    out_word.negative_out = add_hi[3];
                    out_word.acc_out      = {add_hi_fix[3:0], add_lo_fix[3:0]};
                end
                else
                begin
                    out_word.carry_out    = sum[8];
                    out_word.overflow_out = ~(a[7] ^ b[7]) & (a[7] ^ sum[7]);
                    out_word.negative_out = sum[7];
                    out_word.acc_out      = sum[7:0];
                end
            end
        endcase
    end

endmodule

[src/binary_decimal_add_subtract_alu_top.sv]
// binary_decimal_add_subtract_alu_top: registered add/subtract alu with bcd mode
// input register, bdalu_core datapath, result register; depends on bdalu_pkg
//
// Each word passes through an input register and a result register with one
// combinational add/subtract and nibble-fixup pass between them, and one word
// is taken every clock while the output is not stalled. A stalled result is
// held in the result register while the input register may still take one
// more word.
module binary_decimal_add_subtract_alu_top
    import bdalu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [7:0] acc_in,
    input  logic [7:0] operand,
    input  logic       carry_in,
    input  logic       decimal_mode,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] acc_out,
    output logic       carry_out,
    output logic       overflow_out,
    output logic       zero_out,
    output logic       negative_out
);

    logic      s1_valid_reg;
    logic      s1_valid_next;
    in_word_t  s1_word_reg;
    logic      s2_valid_reg;
    logic      s2_valid_next;
    out_word_t s2_word_reg;
    out_word_t core_word;
    logic      s2_load;
    logic      s1_load;

    assign s2_load = ~s2_valid_reg | ~out_stall;
    assign in_stall = s1_valid_reg & ~s2_load;
    assign s1_load = in_valid & ~in_stall;

    assign s1_valid_next = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_reg);
    assign s2_valid_next = s2_load ? s1_valid_reg : s2_valid_reg;

    bdalu_core u_core
    (
        .in_word  (s1_word_reg),
        .out_word (core_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_word_reg <= '{action:       action_t'(action),
                             acc_in:       acc_in,
                             operand:      operand,
                             carry_in:     carry_in,
                             decimal_mode: decimal_mode};
        end
        if (s2_load && s1_valid_reg)
        begin
            s2_word_reg <= core_word;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign acc_out      = s2_word_reg.acc_out;
    assign carry_out    = s2_word_reg.carry_out;
    assign overflow_out = s2_word_reg.overflow_out;
    assign zero_out     = s2_word_reg.zero_out;
    assign negative_out = s2_word_reg.negative_out;

    a_stall_only_when_out_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is free");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s1_load |=> s1_valid_reg)
        else $error("accepted word lost from input register");

    a_binary_add_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_load && s1_valid_reg && (s1_word_reg.action == ACT_ADC)
         && !s1_word_reg.decimal_mode)
        |=> (acc_out == 8'($past(s1_word_reg.acc_in) + $past(s1_word_reg.operand)
                           + {7'd0, $past(s1_word_reg.carry_in)})))
        else $error("binary add result mismatch");

    a_result_needs_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!s2_valid_reg && !s1_valid_reg) |=> !out_valid)
        else $error("result appeared with no word in flight");

endmodule

[tb/sv/tb_binary_decimal_add_subtract_alu_top.sv]
// tb_binary_decimal_add_subtract_alu_top: self-checking bench for the binary/bcd add-subtract alu
// directed corner words, then random binary, bcd and raw words; depends on bdalu_pkg
// and binary_decimal_add_subtract_alu_top
module tb_binary_decimal_add_subtract_alu_top
    import bdalu_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       action;
    logic [7:0] acc_in;
    logic [7:0] operand;
    logic       carry_in;
    logic       decimal_mode;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] acc_out;
    logic       carry_out;
    logic       overflow_out;
    logic       zero_out;
    logic       negative_out;

    out_word_t  awaited_results[$];
    int         mismatches;
    bit         idle_on;

    binary_decimal_add_subtract_alu_top DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .acc_in       (acc_in),
        .operand      (operand),
        .carry_in     (carry_in),
        .decimal_mode (decimal_mode),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .acc_out      (acc_out),
        .carry_out    (carry_out),
        .overflow_out (overflow_out),
        .zero_out     (zero_out),
        .negative_out (negative_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic out_word_t alu_result(input action_t act, input logic [7:0] a,
                                             input logic [7:0] b, input logic c,
                                             input logic dec);
        out_word_t  r;
        logic [9:0] sum;
        logic [8:0] diff;
        logic [7:0] lo;
        logic [7:0] hi;
        logic       borrow;

        if (act == ACT_ADC)
        begin
            sum            = {2'b00, a} + {2'b00, b} + {9'd0, c};
            r.zero_out     = (sum[7:0] == 8'h00);
            if (!dec)
            begin
                r.acc_out      = sum[7:0];
                r.carry_out    = (sum > 10'h0ff);
                r.overflow_out = ~(a[7] ^ b[7]) & (a[7] ^ sum[7]);
                r.negative_out = sum[7];
            end
            else
            begin
                lo = {4'h0, a[3:0]} + {4'h0, b[3:0]} + {7'd0, c};
                if (lo > 8'd9)
                    lo = lo + 8'd6;
                hi = {4'h0, a[7:4]} + {4'h0, b[7:4]};
                if (lo > 8'h0f)
                    hi = hi + 8'd1;
                r.negative_out = hi[3];
                r.overflow_out = (hi[3] ^ a[7]) & ~(a[7] ^ b[7]);
                if (hi > 8'd9)
                    hi = hi + 8'd6;
                r.carry_out    = (hi > 8'h0f);
                r.acc_out      = {hi[3:0], lo[3:0]};
            end
        end
        else
        begin
            borrow         = ~c;
            diff           = {1'b0, a} - {1'b0, b} - {8'd0, borrow};
            r.carry_out    = ~diff[8];
            r.overflow_out = (a[7] ^ diff[7]) & (a[7] ^ b[7]);
            r.zero_out     = (diff[7:0] == 8'h00);
            r.negative_out = diff[7];
            if (!dec)
                r.acc_out = diff[7:0];
            else
            begin
                lo = {4'h0, a[3:0]} - {4'h0, b[3:0]} - {7'd0, borrow};
                hi = {4'h0, a[7:4]} - {4'h0, b[7:4]};
                if (lo[4])
                begin
                    lo = lo - 8'd6;
                    hi = hi - 8'd1;
                end
                if (hi[4])
                    hi = hi - 8'd6;
                r.acc_out = {hi[3:0], lo[3:0]};
            end
        end
        return r;
    endfunction

    task automatic send_word(input action_t act, input logic [7:0] a, input logic [7:0] b,
                             input logic c, input logic dec);
        int gap;

        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        acc_in       <= a;
        operand      <= b;
        carry_in     <= c;
        decimal_mode <= dec;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        awaited_results.push_back(alu_result(act, a, b, c, dec));
    endtask

    task automatic send_random_word(input bit bcd_digits);
        logic [7:0] a;
        logic [7:0] b;

        if (bcd_digits)
        begin
            a = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            b = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            send_word(action_t'($urandom_range(0, 1)), a, b, 1'($urandom_range(0, 1)), 1'b1);
        end
        else
            send_word(action_t'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // result accepted at the next rising edge
    always @(negedge clk)
    begin
        out_word_t exp_w;

        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected word: expected none actual acc %h c %b v %b z %b n %b",
                         $time, acc_out, carry_out, overflow_out, zero_out, negative_out);
            end
            else
            begin
                exp_w = awaited_results.pop_front();
                check_field("acc_out", exp_w.acc_out, acc_out);
                check_field("carry_out", 8'(exp_w.carry_out), 8'(carry_out));
                check_field("overflow_out", 8'(exp_w.overflow_out), 8'(overflow_out));
                check_field("zero_out", 8'(exp_w.zero_out), 8'(zero_out));
                check_field("negative_out", 8'(exp_w.negative_out), 8'(negative_out));
            end
        end
    end

    initial
    begin
        int n;

        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 15);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 15) == 0)
                repeat ($urandom_range(20, 60)) @(posedge clk);
        end
    end

    task automatic test_binary_corners();
        send_word(ACT_ADC, 8'h00, 8'h00, 1'b0, 1'b0);
        send_word(ACT_ADC, 8'hff, 8'hff, 1'b1, 1'b0);
        send_word(ACT_ADC, 8'h7f, 8'h01, 1'b0, 1'b0);
        send_word(ACT_ADC, 8'h80, 8'h80, 1'b0, 1'b0);
        send_word(ACT_ADC, 8'hff, 8'h00, 1'b1, 1'b0);
        send_word(ACT_SBC, 8'h00, 8'h01, 1'b1, 1'b0);
        send_word(ACT_SBC, 8'h80, 8'h01, 1'b1, 1'b0);
        send_word(ACT_SBC, 8'h7f, 8'hff, 1'b1, 1'b0);
        send_word(ACT_SBC, 8'h00, 8'h00, 1'b0, 1'b0);
        send_word(ACT_SBC, 8'h55, 8'h55, 1'b1, 1'b0);
    endtask

    task automatic test_decimal_corners();
        // sum zero from the binary result, bcd result wraps to 00
        send_word(ACT_ADC, 8'h99, 8'h01, 1'b0, 1'b1);
        send_word(ACT_ADC, 8'h09, 8'h01, 1'b0, 1'b1);
        send_word(ACT_ADC, 8'h58, 8'h46, 1'b1, 1'b1);
        send_word(ACT_ADC, 8'h50, 8'h50, 1'b0, 1'b1);
        send_word(ACT_ADC, 8'h79, 8'h00, 1'b1, 1'b1);
        // non-bcd digits in the adds, then subtracts with bcd and non-bcd digits
        send_word(ACT_ADC, 8'h0f, 8'h0f, 1'b0, 1'b1);
        send_word(ACT_ADC, 8'hff, 8'hff, 1'b1, 1'b1);
        send_word(ACT_SBC, 8'h00, 8'h01, 1'b1, 1'b1);
        send_word(ACT_SBC, 8'h10, 8'h01, 1'b1, 1'b1);
        send_word(ACT_SBC, 8'h99, 8'h99, 1'b0, 1'b1);
        send_word(ACT_SBC, 8'h0a, 8'h00, 1'b1, 1'b1);
        send_word(ACT_SBC, 8'hff, 8'hff, 1'b1, 1'b1);
        send_word(ACT_SBC, 8'h00, 8'h99, 1'b0, 1'b1);
        send_word(ACT_SBC, 8'h80, 8'h01, 1'b1, 1'b1);
    endtask

    task automatic test_random_bcd();
        repeat (500) send_random_word(1'b1);
    endtask

    task automatic test_random_raw();
        repeat (500) send_random_word(1'b0);
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (280) send_random_word(1'($urandom_range(0, 1)));
        in_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        action       <= ACT_ADC;
        acc_in       <= 8'h00;
        operand      <= 8'h00;
        carry_in     <= 1'b0;
        decimal_mode <= 1'b0;
        mismatches   = 0;
        idle_on      = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_binary_corners();
        test_decimal_corners();
        test_random_bcd();
        test_random_raw();
        test_back_to_back();

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("binary_decimal_add_subtract_alu_top verification clean");
        else
            $display("binary_decimal_add_subtract_alu_top verification failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("binary_decimal_add_subtract_alu_top verification failed");
        $finish;
    end

endmodule

[binary_decimal_add_subtract_alu_top.f]
src/bdalu_pkg.sv
src/bdalu_core.sv
src/binary_decimal_add_subtract_alu_top.sv
tb/sv/tb_binary_decimal_add_subtract_alu_top.sv
